@@ rtl/core/packet_ingress_stats_fifo_top_defines.svh @@
// Assertion macros shared by the packet ingress statistics FIFO.
`ifndef PACKET_INGRESS_STATS_FIFO_TOP_DEFINES_SVH
`define PACKET_INGRESS_STATS_FIFO_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge of i_clk, ignored while reset is applied.
`define PISF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pisf assertion failed");
// Checked on every rising edge of i_clk, reset included.
`define PISF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("pisf assertion failed");
`else
`define PISF_ASSERT(lbl, prop)
`define PISF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/core/pisf_pkg.sv @@
// Types and constants of the packet ingress statistics FIFO.
package pisf_pkg;

    localparam int CAPACITY  = 1024;
    localparam int NUM_PORTS = 4;
    localparam int NUM_CFG   = 4;

    localparam int RING_AW   = $clog2(CAPACITY);
    localparam int CFG_IDX_W = $clog2(NUM_CFG);
    localparam int CFG_W     = 32;
    localparam int LEVEL_W   = 10;
    localparam int CNT_W     = 64;
    localparam int SEL_W     = 4;

    localparam logic [RING_AW-1:0] OCC_MAX = RING_AW'(CAPACITY - 2);

    typedef enum logic [1:0] {
        CMD_CAPTURE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_STAT    = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_QUEUED  = 3'd0,
        ST_INVALID = 3'd1,
        ST_DROPPED = 3'd2,
        ST_POPPED  = 3'd3,
        ST_IDLE    = 3'd4
    } t_status;

    localparam logic [SEL_W-1:0] SEL_PKTS   = 4'd0;
    localparam logic [SEL_W-1:0] SEL_BYTES  = 4'd1;
    localparam logic [SEL_W-1:0] SEL_DROPS  = 4'd2;
    localparam logic [SEL_W-1:0] SEL_ERRORS = 4'd3;
    localparam int               SEL_PORT_BASE = 4;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic [15:0] length;
        logic [7:0]  flags;
        logic [63:0] stamp;
        logic [31:0] iface;
    } t_desc;

    localparam int DESC_W = $bits(t_desc);

    // Counter update request for one accepted item.
    typedef struct packed {
        logic counted;
        logic invalid;
        logic drop;
    } t_stat_upd;

endpackage

@@ rtl/core/pisf_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module pisf_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/pisf_stats.sv @@
// Port slot registers, traffic counters and counter read selection.
module pisf_stats (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [pisf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pisf_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  pisf_pkg::t_stat_upd      i_upd,
    input  logic [15:0]              i_length,
    input  logic [31:0]              i_iface,
    input  logic [pisf_pkg::SEL_W-1:0]     i_stat_select,
    output logic [pisf_pkg::CNT_W-1:0]     o_stat_value
);
    import pisf_pkg::*;

    logic [31:0]      r_port_id    [NUM_PORTS];
    logic [CNT_W-1:0] r_port_pkts  [NUM_PORTS];
    logic [CNT_W-1:0] r_port_bytes [NUM_PORTS];
    logic [CNT_W-1:0] r_total_pkts;
    logic [CNT_W-1:0] r_total_bytes;
    logic [CNT_W-1:0] r_drop_count;
    logic [CNT_W-1:0] r_error_count;
    logic [NUM_PORTS-1:0] w_hit;
    logic [CNT_W-1:0] w_len_ext;

    assign w_len_ext = CNT_W'(i_length);

    // Only the lowest-numbered slot with a matching nonzero id counts.
    always_comb begin : match_blk
        logic found;
        found = 1'b0;
        w_hit = '0;
        for (int j = 0; j < NUM_PORTS; j++) begin
            if (!found && r_port_id[j] != '0 && r_port_id[j] == i_iface) begin
                w_hit[j] = 1'b1;
                found    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_pkts  <= '0;
            r_total_bytes <= '0;
            r_drop_count  <= '0;
            r_error_count <= '0;
            for (int j = 0; j < NUM_PORTS; j++) begin
                r_port_id[j]    <= '0;
                r_port_pkts[j]  <= '0;
                r_port_bytes[j] <= '0;
            end
        end else begin
            for (int j = 0; j < NUM_PORTS; j++) begin
                if (i_cfg_we && j < NUM_CFG && int'(i_cfg_idx) == j) begin
                    r_port_id[j] <= i_cfg_wdata;
                end
                if (i_upd.counted && w_hit[j]) begin
                    r_port_pkts[j]  <= r_port_pkts[j] + 1'b1;
                    r_port_bytes[j] <= r_port_bytes[j] + w_len_ext;
                end
            end
            if (i_upd.counted) begin
                r_total_pkts  <= r_total_pkts + 1'b1;
                r_total_bytes <= r_total_bytes + w_len_ext;
            end
            if (i_upd.drop) begin
                r_drop_count <= r_drop_count + 1'b1;
            end
            if (i_upd.invalid) begin
                r_error_count <= r_error_count + 1'b1;
            end
        end
    end

    // Selectors past the last port slot read as zero.
    always_comb begin
        o_stat_value = '0;
        case (i_stat_select)
            SEL_PKTS:   o_stat_value = r_total_pkts;
            SEL_BYTES:  o_stat_value = r_total_bytes;
            SEL_DROPS:  o_stat_value = r_drop_count;
            SEL_ERRORS: o_stat_value = r_error_count;
            default: begin
                for (int j = 0; j < NUM_PORTS; j++) begin
                    if (int'(i_stat_select) == SEL_PORT_BASE + 2 * j) begin
                        o_stat_value = r_port_pkts[j];
                    end
                    if (int'(i_stat_select) == SEL_PORT_BASE + 2 * j + 1) begin
                        o_stat_value = r_port_bytes[j];
                    end
                end
            end
        endcase
    end

endmodule

@@ rtl/core/packet_ingress_stats_fifo_top.sv @@
// Top level of the packet ingress statistics FIFO.
// The block takes one command per clock: o_busy stays low, so every cycle with
// i_start high is a transfer. Each command gives exactly one result, shown on
// the output ports for one cycle with o_done high, after the stage 1 register
// and the output register; the receiver cannot stall, so it must take every
// o_done cycle. The descriptor RAM's read data is registered in stage 1 and
// then passes the output register. Counters are written in the transfer cycle,
// port slot registers whenever i_cfg_we is high; a stat read issued right after
// a capture already sees the capture counted. The ring keeps at most
// CAPACITY-2 descriptors.
`include "packet_ingress_stats_fifo_top_defines.svh"

module packet_ingress_stats_fifo_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    output logic                     o_done,
    input  logic                     i_cfg_we,
    input  logic [pisf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pisf_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic [1:0]               i_cmd,
    input  logic [31:0]              i_src_addr,
    input  logic [31:0]              i_dst_addr,
    input  logic [15:0]              i_src_port_num,
    input  logic [15:0]              i_dst_port_num,
    input  logic [7:0]               i_proto,
    input  logic [15:0]              i_length,
    input  logic [63:0]              i_stamp,
    input  logic [7:0]               i_flag_bits,
    input  logic [31:0]              i_iface,
    input  logic [3:0]               i_stat_select,
    output logic [2:0]               o_status,
    output logic [31:0]              o_out_src_addr,
    output logic [31:0]              o_out_dst_addr,
    output logic [15:0]              o_out_src_port,
    output logic [15:0]              o_out_dst_port,
    output logic [7:0]               o_out_proto,
    output logic [15:0]              o_out_length,
    output logic [63:0]              o_out_stamp,
    output logic [7:0]               o_out_flags,
    output logic [31:0]              o_out_iface,
    output logic [9:0]               o_level,
    output logic [63:0]              o_stat_value
);
    import pisf_pkg::*;

    logic               w_accept;
    logic [RING_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [RING_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [RING_AW-1:0] r_occ, n_occ;
    logic               w_ram_we;
    logic               w_ram_re;
    t_desc              w_wdesc;
    t_desc              w_rdesc;
    t_status            n_status;
    t_stat_upd          w_upd;
    logic [CNT_W-1:0]   w_stat;
    logic [CNT_W-1:0]   n_stat;

    // Stage 1: command decided, RAM read in flight.
    logic               r_s1_vld;
    t_status            r_s1_status;
    logic               r_s1_pop;
    logic [RING_AW-1:0] r_s1_occ;
    logic [CNT_W-1:0]   r_s1_stat;

    // Stage 2: output register.
    logic               r_done;
    t_status            r_status;
    t_desc              r_odesc;
    logic [LEVEL_W-1:0] r_level;
    logic [CNT_W-1:0]   r_stat;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    assign w_wdesc = '{
        src_addr: i_src_addr,
        dst_addr: i_dst_addr,
        sport:    i_src_port_num,
        dport:    i_dst_port_num,
        proto:    i_proto,
        length:   i_length,
        flags:    i_flag_bits,
        stamp:    i_stamp,
        iface:    i_iface
    };

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_occ    = r_occ;
        n_status = ST_IDLE;
        n_stat   = '0;
        w_ram_we = 1'b0;
        w_ram_re = 1'b0;
        w_upd    = '0;
        if (w_accept) begin
            case (i_cmd)
                CMD_CAPTURE: begin
                    if (i_src_addr == '0 || i_dst_addr == '0 || i_length == '0) begin
                        w_upd.invalid = 1'b1;
                        n_status      = ST_INVALID;
                    end else begin
                        w_upd.counted = 1'b1;
                        if (r_occ >= OCC_MAX) begin
                            w_upd.drop = 1'b1;
                            n_status   = ST_DROPPED;
                        end else begin
                            w_ram_we = 1'b1;
                            n_wr_ptr = r_wr_ptr + 1'b1;
                            n_occ    = r_occ + 1'b1;
                            n_status = ST_QUEUED;
                        end
                    end
                end
                CMD_DEQUEUE: begin
                    if (r_occ != '0) begin
                        w_ram_re = 1'b1;
                        n_rd_ptr = r_rd_ptr + 1'b1;
                        n_occ    = r_occ - 1'b1;
                        n_status = ST_POPPED;
                    end
                end
                CMD_STAT: begin
                    n_stat = w_stat;
                end
                default: begin
                    n_status = ST_IDLE;
                end
            endcase
        end
    end

    // The ring never fills completely, so a write and the oldest entry
    // never share an address while the ring holds data.
    pisf_ram #(
        .W(DESC_W),
        .D(CAPACITY)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (w_wdesc),
        .i_re    (w_ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_rdesc)
    );

    pisf_stats u_stats (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_upd         (w_upd),
        .i_length      (i_length),
        .i_iface       (i_iface),
        .i_stat_select (i_stat_select),
        .o_stat_value  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_occ    <= '0;
            r_s1_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_occ    <= n_occ;
            r_s1_vld <= w_accept;
            r_done   <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_status <= n_status;
        r_s1_pop    <= w_ram_re;
        r_s1_occ    <= n_occ;
        r_s1_stat   <= n_stat;
        r_status    <= r_s1_status;
        r_odesc     <= r_s1_pop ? w_rdesc : '0;
        r_level     <= LEVEL_W'(r_s1_occ);
        r_stat      <= r_s1_stat;
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_out_src_addr = r_odesc.src_addr;
    assign o_out_dst_addr = r_odesc.dst_addr;
    assign o_out_src_port = r_odesc.sport;
    assign o_out_dst_port = r_odesc.dport;
    assign o_out_proto    = r_odesc.proto;
    assign o_out_length   = r_odesc.length;
    assign o_out_stamp    = r_odesc.stamp;
    assign o_out_flags    = r_odesc.flags;
    assign o_out_iface    = r_odesc.iface;
    assign o_level        = r_level;
    assign o_stat_value   = r_stat;

    `PISF_ASSERT(a_occ_limit, r_occ <= OCC_MAX)
    `PISF_ASSERT(a_ptr_occ, RING_AW'(r_wr_ptr - r_rd_ptr) == r_occ)
    `PISF_ASSERT(a_result_follows, w_accept |=> ##1 o_done)
    `PISF_ASSERT_ALWAYS(a_done_has_cause, o_done |-> $past(w_accept, 2))

endmodule
